@@ rtl/cavg_pkg.sv @@
package cavg_pkg;

    localparam int COORD_W       = 32;
    localparam int ANG_W         = 35;
    localparam int TRIG_W        = 34;
    localparam int CNT_W         = 6;
    localparam int SEG_W         = 8;
    localparam int QUO_W         = 33;
    localparam int REM_W         = CNT_W + 1;
    localparam int DIV_IT_W      = 6;
    localparam int CORDIC_STEPS  = 28;
    localparam int ROT_IT_W      = 5;
    localparam int TRIG_FRAC     = 30;
    localparam int ANG_FRAC      = 28;
    localparam int PROD_W        = COORD_W + TRIG_W;
    localparam int DEF_MAX_POINTS = 61;

    localparam int PI_INT        = 843314857;
    localparam int HALF_PI_INT   = 421657428;
    localparam int TWO_PI_INT    = 1686629713;
    localparam int GAIN_INT      = 652032874;

    localparam logic signed [ANG_W-1:0]  PI_Q28      = ANG_W'(PI_INT);
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q28 = ANG_W'(HALF_PI_INT);
    localparam logic signed [ANG_W-1:0]  TWO_PI_Q28  = ANG_W'(TWO_PI_INT);
    localparam logic [QUO_W-1:0]         TWO_PI_DIV  = QUO_W'(TWO_PI_INT);
    localparam logic signed [TRIG_W-1:0] GAIN_Q30    = TRIG_W'(GAIN_INT);

    localparam logic CMD_CIRCLE = 1'b0;
    localparam logic CMD_ARC    = 1'b1;

    localparam logic [1:0] SEL_RIM   = 2'd0;
    localparam logic [1:0] SEL_CTR   = 2'd1;
    localparam logic [1:0] SEL_FIRST = 2'd2;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic signed [COORD_W-1:0] start_angle;
        logic signed [COORD_W-1:0] end_angle;
        logic [SEG_W-1:0]          segment_count;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } vtx_t;

    typedef struct packed {
        logic       load;
        logic       div_init;
        logic       div_step;
        logic       setup;
        logic       reduce;
        logic       rot_step;
        logic       trig;
        logic       mulx;
        logic       muly;
        logic       place;
        logic       next_pt;
        logic [1:0] out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic circle;
        logic empty;
        logic div_last;
        logic step_zero;
        logic in_range;
        logic rot_last;
        logic last_rim;
    } dp_sts_t;

    function automatic logic signed [ANG_W-1:0] atan_e(input logic [ROT_IT_W-1:0] k);
        logic signed [ANG_W-1:0] r;
        case (k)
            5'd0:    r = ANG_W'(210828714);
            5'd1:    r = ANG_W'(124459457);
            5'd2:    r = ANG_W'(65760959);
            5'd3:    r = ANG_W'(33381290);
            5'd4:    r = ANG_W'(16755422);
            5'd5:    r = ANG_W'(8385879);
            5'd6:    r = ANG_W'(4193963);
            5'd7:    r = ANG_W'(2097109);
            5'd8:    r = ANG_W'(1048571);
            5'd9:    r = ANG_W'(524287);
            default: r = ANG_W'(1) << (ANG_FRAC - int'(k));
        endcase
        return r;
    endfunction

endpackage

@@ rtl/circle_arc_vertex_generator.sv @@
// Circle and arc outline generator.
// Request channel: req_valid/req_stall carry one request word (shape, centre,
// radius, two angles, segment count). Vertex channel: vtx_valid/vtx_stall
// carry one vertex word per point, last_vertex set on the final one.
// One request is worked at a time; req_stall stays high from acceptance
// until the last vertex word is taken (or the request is found empty).
// Per request: a check, restoring division for the angle step, then
// setup. Per rim vertex: angle folding, CORDIC iterations, then the trig
// negate, x multiply, y multiply and placement states, after which the
// word is shown. Circle with P points: P+1 words; arc: P+3 words. The
// centre and the repeated first point are shown straight from registers.
// An empty arc returns no words and frees the input.
// Reset clears the controller to idle; a request in progress is abandoned.
// A stalled vertex word holds its value until taken; nothing else advances.
module circle_arc_vertex_generator #(
    parameter int MAX_POINTS = cavg_pkg::DEF_MAX_POINTS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cavg_pkg::req_t  req,
    output logic            vtx_valid,
    input  logic            vtx_stall,
    output cavg_pkg::vtx_t  vtx
);
    import cavg_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    last_vertex;
    logic signed [COORD_W-1:0] vertex_x, vertex_y;

    cavg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .vtx_valid   (vtx_valid),
        .vtx_stall   (vtx_stall),
        .last_vertex (last_vertex),
        .sts         (sts),
        .cmd         (cmd)
    );

    cavg_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .sts      (sts),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y)
    );

    assign vtx.vertex_x    = vertex_x;
    assign vtx.vertex_y    = vertex_y;
    assign vtx.last_vertex = last_vertex;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid |-> req_stall)
        else $error("vertex shown while request port open");
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (req_stall && !vtx_valid))
        else $error("request port open right after accept");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (vtx_valid && !vtx_stall && vtx.last_vertex) |=> (!vtx_valid && !req_stall))
        else $error("output continues after last vertex");
`endif

endmodule

@@ rtl/cavg_datapath.sv @@
module cavg_datapath #(
    parameter int MAX_POINTS = cavg_pkg::DEF_MAX_POINTS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cavg_pkg::req_t                       req,
    input  cavg_pkg::dp_cmd_t                    cmd,
    output cavg_pkg::dp_sts_t                    sts,
    output logic signed [cavg_pkg::COORD_W-1:0]  vertex_x,
    output logic signed [cavg_pkg::COORD_W-1:0]  vertex_y
);
    import cavg_pkg::*;

    localparam logic [SEG_W-1:0] MAXP_SEG = SEG_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] MAXP_CNT = CNT_W'(MAX_POINTS);

    logic                      arc_reg;
    logic signed [COORD_W-1:0] ctr_x_reg, ctr_y_reg, rad_reg, a1_reg;
    logic signed [QUO_W-1:0]   d_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      cnt_zero_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      neg_reg;
    logic [DIV_IT_W-1:0]       div_it_reg;
    logic signed [ANG_W-1:0]   base_reg, ang_reg;
    logic                      flip_reg;
    logic signed [TRIG_W-1:0]  rx_reg, ry_reg, cos_reg, sin_reg;
    logic [ROT_IT_W-1:0]       rot_it_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [COORD_W-1:0] vx_reg, vy_reg, fx_reg, fy_reg;
    logic [CNT_W-1:0]          k_reg;

    logic [CNT_W-1:0]          sat;
    logic [QUO_W-1:0]          absd;
    logic                      circle;
    logic [REM_W-1:0]          rem_sh;
    logic                      ge;
    logic signed [ANG_W-1:0]   qx, step, e, base_inc, a1_ext;
    logic signed [TRIG_W-1:0]  dx, dy;
    logic signed [PROD_W-1:0]  rnd_sum, rnd_sh;
    logic signed [COORD_W-1:0] rnd;

    always_comb
    begin
        sat      = (req.segment_count > MAXP_SEG) ? MAXP_CNT : req.segment_count[CNT_W-1:0];
        absd     = d_reg[QUO_W-1] ? QUO_W'(-d_reg) : QUO_W'(d_reg);
        circle   = !arc_reg || (absd >= TWO_PI_DIV);
        rem_sh   = {rem_reg[CNT_W-1:0], quo_reg[QUO_W-1]};
        ge       = rem_sh >= {1'b0, cnt_reg};
        qx       = $signed({{(ANG_W-QUO_W){1'b0}}, quo_reg});
        step     = neg_reg ? -qx : qx;
        base_inc = base_reg + step;
        a1_ext   = ANG_W'(a1_reg);
        e        = atan_e(rot_it_reg);
        dx       = ry_reg >>> rot_it_reg;
        dy       = rx_reg >>> rot_it_reg;
        rnd_sum  = prod_reg + (PROD_W'(1) <<< (TRIG_FRAC - 1));
        rnd_sh   = rnd_sum >>> TRIG_FRAC;
        rnd      = rnd_sh[COORD_W-1:0];
    end

    assign sts.circle    = circle;
    assign sts.empty     = arc_reg && (cnt_zero_reg || (d_reg == '0));
    assign sts.div_last  = div_it_reg == DIV_IT_W'(QUO_W - 1);
    assign sts.step_zero = !circle && (quo_reg == '0);
    assign sts.in_range  = !(ang_reg > PI_Q28) && !(ang_reg < -PI_Q28);
    assign sts.rot_last  = rot_it_reg == ROT_IT_W'(CORDIC_STEPS - 1);
    assign sts.last_rim  = circle ? (k_reg == cnt_reg - CNT_W'(1)) : (k_reg == cnt_reg);

    always_comb
    begin
        case (cmd.out_sel)
            SEL_CTR:
            begin
                vertex_x = ctr_x_reg;
                vertex_y = ctr_y_reg;
            end
            SEL_FIRST:
            begin
                vertex_x = fx_reg;
                vertex_y = fy_reg;
            end
            default:
            begin
                vertex_x = vx_reg;
                vertex_y = vy_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_it_reg <= '0;
            rot_it_reg <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (cmd.div_init)
                div_it_reg <= '0;
            else if (cmd.div_step)
                div_it_reg <= div_it_reg + DIV_IT_W'(1);
            if (cmd.reduce)
                rot_it_reg <= '0;
            else if (cmd.rot_step)
                rot_it_reg <= rot_it_reg + ROT_IT_W'(1);
            if (cmd.setup)
                k_reg <= '0;
            else if (cmd.next_pt)
                k_reg <= k_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arc_reg      <= (req.cmd == CMD_ARC);
            ctr_x_reg    <= req.center_x;
            ctr_y_reg    <= req.center_y;
            rad_reg      <= req.radius;
            a1_reg       <= req.start_angle;
            d_reg        <= QUO_W'(req.end_angle) - QUO_W'(req.start_angle);
            cnt_reg      <= (sat == '0) ? CNT_W'(1) : sat;
            cnt_zero_reg <= sat == '0;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= circle ? TWO_PI_DIV : absd;
            neg_reg <= !circle && d_reg[QUO_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_sh - {1'b0, cnt_reg} : rem_sh;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
        if (cmd.setup)
        begin
            base_reg <= circle ? '0 : a1_ext;
            ang_reg  <= circle ? '0 : a1_ext;
        end
        else if (cmd.next_pt)
        begin
            base_reg <= base_inc;
            ang_reg  <= base_inc;
        end
        else if (cmd.reduce)
        begin
            if (ang_reg > PI_Q28)
                ang_reg <= ang_reg - TWO_PI_Q28;
            else if (ang_reg < -PI_Q28)
                ang_reg <= ang_reg + TWO_PI_Q28;
            else
            begin
                rx_reg <= GAIN_Q30;
                ry_reg <= '0;
                if (ang_reg > HALF_PI_Q28)
                begin
                    ang_reg  <= ang_reg - PI_Q28;
                    flip_reg <= 1'b1;
                end
                else if (ang_reg < -HALF_PI_Q28)
                begin
                    ang_reg  <= ang_reg + PI_Q28;
                    flip_reg <= 1'b1;
                end
                else
                    flip_reg <= 1'b0;
            end
        end
        else if (cmd.rot_step)
        begin
            if (!ang_reg[ANG_W-1])
            begin
                rx_reg  <= rx_reg - dx;
                ry_reg  <= ry_reg + dy;
                ang_reg <= ang_reg - e;
            end
            else
            begin
                rx_reg  <= rx_reg + dx;
                ry_reg  <= ry_reg - dy;
                ang_reg <= ang_reg + e;
            end
        end
        if (cmd.trig)
        begin
            cos_reg <= flip_reg ? -rx_reg : rx_reg;
            sin_reg <= flip_reg ? -ry_reg : ry_reg;
        end
        if (cmd.mulx)
            prod_reg <= PROD_W'(rad_reg) * PROD_W'(cos_reg);
        if (cmd.muly)
        begin
            prod_reg <= PROD_W'(rad_reg) * PROD_W'(sin_reg);
            vx_reg   <= ctr_x_reg + rnd;
        end
        if (cmd.place)
        begin
            vy_reg <= ctr_y_reg + rnd;
            if (k_reg == '0)
            begin
                fx_reg <= vx_reg;
                fy_reg <= ctr_y_reg + rnd;
            end
        end
    end

endmodule

@@ rtl/cavg_ctrl.sv @@
module cavg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                vtx_valid,
    input  logic                vtx_stall,
    output logic                last_vertex,
    input  cavg_pkg::dp_sts_t   sts,
    output cavg_pkg::dp_cmd_t   cmd
);
    import cavg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_CTR0  = 4'd4;
    localparam logic [3:0] S_RED   = 4'd5;
    localparam logic [3:0] S_ROT   = 4'd6;
    localparam logic [3:0] S_TRIG  = 4'd7;
    localparam logic [3:0] S_MULX  = 4'd8;
    localparam logic [3:0] S_MULY  = 4'd9;
    localparam logic [3:0] S_PLACE = 4'd10;
    localparam logic [3:0] S_RIM   = 4'd11;
    localparam logic [3:0] S_LAST  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       last_first_reg, last_first_next;
    logic       take;

    assign take = !vtx_stall;

    always_comb
    begin
        state_next      = state_reg;
        last_first_next = last_first_reg;
        cmd             = '0;
        cmd.out_sel     = SEL_RIM;
        req_stall       = 1'b1;
        vtx_valid       = 1'b0;
        last_vertex     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.empty)
                    state_next = S_IDLE;
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                if (sts.step_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.setup       = 1'b1;
                    last_first_next = sts.circle;
                    state_next      = sts.circle ? S_RED : S_CTR0;
                end
            end
            S_CTR0:
            begin
                vtx_valid   = 1'b1;
                cmd.out_sel = SEL_CTR;
                if (take)
                    state_next = S_RED;
            end
            S_RED:
            begin
                cmd.reduce = 1'b1;
                if (sts.in_range)
                    state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (sts.rot_last)
                    state_next = S_TRIG;
            end
            S_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = S_MULX;
            end
            S_MULX:
            begin
                cmd.mulx   = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.muly   = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_RIM;
            end
            S_RIM:
            begin
                vtx_valid = 1'b1;
                if (take)
                begin
                    cmd.next_pt = 1'b1;
                    state_next  = sts.last_rim ? S_LAST : S_RED;
                end
            end
            S_LAST:
            begin
                vtx_valid   = 1'b1;
                last_vertex = 1'b1;
                cmd.out_sel = last_first_reg ? SEL_FIRST : SEL_CTR;
                if (take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_first_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_first_reg <= last_first_next;
        end
    end

endmodule
